### rtl/core/gbfs_pkg.sv
package gbfs_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int NCELLS   = MAX_ROWS * MAX_COLS;
   localparam int AW       = $clog2(NCELLS);
   localparam int HW       = 7;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_WALK = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  cell_row;
      logic [5:0]  cell_col;
      logic [7:0]  cell_code;
      logic [5:0]  goal_row;
      logic [5:0]  goal_col;
      logic [11:0] step_index;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [12:0] path_length;
      logic        step_valid;
      logic [5:0]  step_row;
      logic [5:0]  step_col;
   } rsp_type;

   typedef struct packed {
      logic          is_open;
      logic          is_closed;
      logic [HW-1:0] heur;
   } cell_state_type;

   // 8-neighbor offsets, row-major order, center skipped
   localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                               2'sd0, 2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] NB_DC [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                               2'sd1, -2'sd1, 2'sd0, 2'sd1};

endpackage

### rtl/core/gbfs_ram.sv
module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/core/grid_best_first_path_search.sv
// Greedy best-first path search on a grid of up to 64x64 8-bit cell codes.
// Every item gives exactly one result, shown for one cycle on rsp_valid; the
// receiver cannot stall, so it must take each result when it appears. A new
// item is taken when start is high and busy is low. A cell write, and a path
// read whose index lies past the stored path, answer from idle; a path read
// within the path first waits on the path memory. A search whose start or goal
// lies off the grid answers from idle; otherwise it first clears every entry
// of the per-cell mark memory, then each expansion scans the whole mark memory
// through its single read port and then handles each neighbor (the heuristic
// square root is found one bit a cycle), and success adds two walks over the
// parent links.
module grid_best_first_path_search
   import gbfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req,
   output logic       rsp_valid,
   output rsp_type    rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDWAIT = 4'd1;
   localparam logic [3:0] S_CLR    = 4'd2;
   localparam logic [3:0] S_HPREP  = 4'd3;
   localparam logic [3:0] S_HROOT  = 4'd4;
   localparam logic [3:0] S_HDONE  = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_CLOSE  = 4'd8;
   localparam logic [3:0] S_NB     = 4'd9;
   localparam logic [3:0] S_NBWAIT = 4'd10;
   localparam logic [3:0] S_NBPAR  = 4'd11;
   localparam logic [3:0] S_W1CHK  = 4'd12;
   localparam logic [3:0] S_W1WAIT = 4'd13;
   localparam logic [3:0] S_W2     = 4'd14;
   localparam logic [3:0] S_W2WAIT = 4'd15;

   // config
   logic [6:0] rows_ff, cols_ff;
   logic [7:0] walk_ff;
   logic [6:0] rows_c, cols_c;

   // control
   logic [3:0]    state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          found_ff, found_in;
   logic [12:0]   slen_ff, slen_in;
   logic [AW-1:0] start_ff, start_in, goal_ff, goal_in;
   logic [13:0]   area_ff, area_in;
   logic [12:0]   cnt_ff, cnt_in;        // clear / scan sweep
   logic [11:0]   count_ff, count_in;    // expansion count
   logic [12:0]   nopen_ff, nopen_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic          bvld_ff, bvld_in;
   logic [AW-1:0] best_ff, best_in;
   logic [HW-1:0] besth_ff, besth_in;
   logic [2:0]    nb_ff, nb_in;
   logic [AW-1:0] n_ff, n_in;
   logic [5:0]    hr_ff, hr_in, hc_ff, hc_in;
   logic          hret_ff, hret_in;      // 1: heuristic is for the start cell
   logic [12:0]   sq_ff, sq_in;
   logic [HW-1:0] root_ff, root_in;
   logic [2:0]    bit_ff, bit_in;
   logic [AW-1:0] p_ff, p_in;
   logic [12:0]   len_ff, len_in;
   logic [12:0]   wn_ff, wn_in;

   // memories
   logic           map_we;
   logic [AW-1:0]  map_waddr, map_raddr;
   logic [7:0]     map_rd;
   logic           st_we;
   logic [AW-1:0]  st_waddr, st_raddr;
   cell_state_type st_wd, st_rd;
   logic           par_we;
   logic [AW-1:0]  par_waddr, par_raddr, par_wd, par_rd;
   logic           path_we;
   logic [AW-1:0]  path_waddr, path_raddr, path_wd, path_rd;

   gbfs_ram #(.WIDTH(8), .DEPTH(NCELLS)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(req.cell_code),
      .raddr(map_raddr), .rdata(map_rd));
   gbfs_ram #(.WIDTH($bits(cell_state_type)), .DEPTH(NCELLS)) u_state (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wd),
      .raddr(st_raddr), .rdata(st_rd));
   gbfs_ram #(.WIDTH(AW), .DEPTH(NCELLS)) u_parent (
      .clock(clock), .we(par_we), .waddr(par_waddr), .wdata(par_wd),
      .raddr(par_raddr), .rdata(par_rd));
   gbfs_ram #(.WIDTH(AW), .DEPTH(NCELLS)) u_path (
      .clock(clock), .we(path_we), .waddr(path_waddr), .wdata(path_wd),
      .raddr(path_raddr), .rdata(path_rd));

   assign rows_c = (rows_ff == 7'd0) ? 7'd1 :
                   (rows_ff > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_ff;
   assign cols_c = (cols_ff == 7'd0) ? 7'd1 :
                   (cols_ff > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_ff;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd64;
         cols_ff <= 7'd64;
         walk_ff <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata[6:0];
            CSR_COLS: cols_ff <= csr_wdata[6:0];
            CSR_WALK: walk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [7:0] ni, nj;
   logic [5:0]        dr, dc;
   logic [HW-1:0]     trial;
   logic [13:0]       three_cnt;
   logic              nb_last;

   always_comb begin
      ni = $signed({2'b00, cur_ff[11:6]}) + 8'(NB_DR[nb_ff]);
      nj = $signed({2'b00, cur_ff[5:0]}) + 8'(NB_DC[nb_ff]);
      dr = (hr_ff > goal_ff[11:6]) ? hr_ff - goal_ff[11:6] : goal_ff[11:6] - hr_ff;
      dc = (hc_ff > goal_ff[5:0]) ? hc_ff - goal_ff[5:0] : goal_ff[5:0] - hc_ff;
      trial = root_ff | (HW'(1) << bit_ff);
      three_cnt = 14'(count_ff) + {1'b0, count_ff, 1'b0};
      nb_last = (nb_ff == 3'd7);
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      found_in = found_ff;
      slen_in = slen_ff;
      start_in = start_ff;
      goal_in = goal_ff;
      area_in = area_ff;
      cnt_in = cnt_ff;
      count_in = count_ff;
      nopen_in = nopen_ff;
      cur_in = cur_ff;
      bvld_in = bvld_ff;
      best_in = best_ff;
      besth_in = besth_ff;
      nb_in = nb_ff;
      n_in = n_ff;
      hr_in = hr_ff;
      hc_in = hc_ff;
      hret_in = hret_ff;
      sq_in = sq_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      p_in = p_ff;
      len_in = len_ff;
      wn_in = wn_ff;

      map_we = 1'b0;
      map_waddr = {req.cell_row, req.cell_col};
      map_raddr = AW'({ni[5:0], nj[5:0]});
      st_we = 1'b0;
      st_waddr = n_ff;
      st_wd = '0;
      st_raddr = cnt_ff[AW-1:0];
      par_we = 1'b0;
      par_waddr = n_ff;
      par_wd = cur_ff;
      par_raddr = p_ff;
      path_we = 1'b0;
      path_waddr = AW'(len_ff - 13'd1 - wn_ff);
      path_wd = p_ff;
      path_raddr = req.step_index;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.step_valid = 1'b0;
               rsp_in.step_row = '0;
               rsp_in.step_col = '0;
               rsp_in.found = found_ff;
               rsp_in.path_length = slen_ff;
               case (req.action)
                  ACT_WRITE: begin
                     map_we = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_SEARCH: begin
                     found_in = 1'b0;
                     slen_in = '0;
                     rsp_in.found = 1'b0;
                     rsp_in.path_length = '0;
                     if ({1'b0, req.cell_row} >= rows_c || {1'b0, req.cell_col} >= cols_c ||
                         {1'b0, req.goal_row} >= rows_c || {1'b0, req.goal_col} >= cols_c) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        start_in = {req.cell_row, req.cell_col};
                        goal_in = {req.goal_row, req.goal_col};
                        area_in = {7'd0, rows_c} * {7'd0, cols_c};
                        cnt_in = '0;
                        state_in = S_CLR;
                     end
                  end
                  ACT_READ: begin
                     if (13'(req.step_index) < slen_ff) begin
                        state_in = S_RDWAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_in.step_valid = 1'b1;
            rsp_in.step_row = path_rd[11:6];
            rsp_in.step_col = path_rd[5:0];
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_CLR: begin
            st_we = 1'b1;
            st_waddr = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 13'd1;
            if (cnt_ff == 13'(NCELLS - 1)) begin
               hr_in = start_ff[11:6];
               hc_in = start_ff[5:0];
               hret_in = 1'b1;
               state_in = S_HPREP;
            end
         end
         S_HPREP: begin
            sq_in = ({7'd0, dr} * {7'd0, dr}) + ({7'd0, dc} * {7'd0, dc});
            root_in = '0;
            bit_in = 3'(HW - 1);
            state_in = S_HROOT;
         end
         S_HROOT: begin
            if (({7'd0, trial} * {7'd0, trial}) <= {1'b0, sq_ff}) begin
               root_in = trial;
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = S_HDONE;
            end
         end
         S_HDONE: begin
            st_we = 1'b1;
            st_wd.is_open = 1'b1;
            st_wd.heur = root_ff;
            par_we = 1'b1;
            if (hret_ff) begin
               st_waddr = start_ff;
               par_waddr = start_ff;
               par_wd = start_ff;
               nopen_in = 13'd1;
               cur_in = start_ff;
               count_in = '0;
               state_in = S_CHECK;
            end else begin
               nopen_in = nopen_ff + 13'd1;
               if (nb_last) state_in = S_CHECK;
               else begin
                  nb_in = nb_ff + 3'd1;
                  state_in = S_NB;
               end
            end
         end
         S_CHECK: begin
            if (cur_ff != goal_ff && nopen_ff != '0 && three_cnt <= {area_ff[12:0], 1'b0}) begin
               count_in = count_ff + 12'd1;
               cnt_in = '0;
               bvld_in = 1'b0;
               state_in = S_SCAN;
            end else if (nopen_ff == '0 || three_cnt > {area_ff[12:0], 1'b0}) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               p_in = goal_ff;
               wn_in = 13'd1;
               state_in = S_W1CHK;
            end
         end
         S_SCAN: begin
            // data for address cnt-1 is on the read port
            if (cnt_ff != '0 && st_rd.is_open && (!bvld_ff || st_rd.heur < besth_ff)) begin
               bvld_in = 1'b1;
               best_in = AW'(cnt_ff - 13'd1);
               besth_in = st_rd.heur;
            end
            cnt_in = cnt_ff + 13'd1;
            if (cnt_ff == 13'(NCELLS)) begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            st_we = 1'b1;
            st_waddr = best_ff;
            st_wd.is_closed = 1'b1;
            st_wd.heur = besth_ff;
            cur_in = best_ff;
            nopen_in = nopen_ff - 13'd1;
            nb_in = '0;
            state_in = S_NB;
         end
         S_NB: begin
            par_raddr = AW'({ni[5:0], nj[5:0]});
            st_raddr = AW'({ni[5:0], nj[5:0]});
            if (ni >= 8'sd0 && ni < $signed({1'b0, rows_c}) &&
                nj >= 8'sd0 && nj < $signed({1'b0, cols_c})) begin
               n_in = AW'({ni[5:0], nj[5:0]});
               hr_in = ni[5:0];
               hc_in = nj[5:0];
               state_in = S_NBWAIT;
            end else if (nb_last) begin
               state_in = S_CHECK;
            end else begin
               nb_in = nb_ff + 3'd1;
            end
         end
         S_NBWAIT: begin
            st_raddr = par_rd;
            if (map_rd != walk_ff || st_rd.is_closed) begin
               if (nb_last) state_in = S_CHECK;
               else begin
                  nb_in = nb_ff + 3'd1;
                  state_in = S_NB;
               end
            end else if (st_rd.is_open) begin
               state_in = S_NBPAR;
            end else begin
               hret_in = 1'b0;
               state_in = S_HPREP;
            end
         end
         S_NBPAR: begin
            // reparent when the expanded cell is no closer than the old parent
            if (besth_ff >= st_rd.heur) begin
               par_we = 1'b1;
            end
            if (nb_last) state_in = S_CHECK;
            else begin
               nb_in = nb_ff + 3'd1;
               state_in = S_NB;
            end
         end
         S_W1CHK: begin
            // first walk counts the path length
            if (p_ff == start_ff || wn_ff == 13'(NCELLS)) begin
               len_in = wn_ff;
               p_in = goal_ff;
               wn_in = '0;
               state_in = S_W2;
            end else begin
               state_in = S_W1WAIT;
            end
         end
         S_W1WAIT: begin
            p_in = par_rd;
            wn_in = wn_ff + 13'd1;
            state_in = S_W1CHK;
         end
         S_W2: begin
            // second walk stores cells back to front
            path_we = 1'b1;
            if (wn_ff == len_ff - 13'd1) begin
               found_in = 1'b1;
               slen_in = len_ff;
               rsp_in.found = 1'b1;
               rsp_in.path_length = len_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_W2WAIT;
            end
         end
         S_W2WAIT: begin
            p_in = par_rd;
            wn_in = wn_ff + 13'd1;
            state_in = S_W2;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         slen_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
         slen_ff <= slen_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      start_ff <= start_in;
      goal_ff <= goal_in;
      area_ff <= area_in;
      cnt_ff <= cnt_in;
      count_ff <= count_in;
      nopen_ff <= nopen_in;
      cur_ff <= cur_in;
      bvld_ff <= bvld_in;
      best_ff <= best_in;
      besth_ff <= besth_in;
      nb_ff <= nb_in;
      n_ff <= n_in;
      hr_ff <= hr_in;
      hc_ff <= hc_in;
      hret_ff <= hret_in;
      sq_ff <= sq_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      p_ff <= p_in;
      len_ff <= len_in;
      wn_ff <= wn_in;
   end

endmodule
